// File: src/qpwht_pkg.sv
// Package for the quadratic-probe word hash table.
// Shared constants, status codes and controller/datapath command types.
package qpwht_pkg;
  localparam int TABLE_SIZE_DEF = 16381;
  localparam int MAX_WORD_DEF   = 20;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_LONG     = 2'd3;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef struct packed {
    logic accum;      // add in_tdata character to pending word
    logic start;      // load probe state from pending key
    logic rd;         // issue table read at current probe slot
    logic wr;         // write pending word at current slot
    logic step;       // advance to next probe
    logic clr_pend;   // clear pending word
    logic clr_mark;   // clearing pass write
  } qpwht_cmd_t;

  typedef struct packed {
    logic used;       // slot under probe is used
    logic match;      // stored word equals pending word
    logic overlong;   // pending word too long
    logic exhausted;  // probe count reached table size
    logic clr_done;   // clearing pass finished
  } qpwht_sts_t;
endpackage

// File: src/qpwht_datapath.sv
// Datapath: pending word, key, probe address generation and slot storage.
// Depends on qpwht_pkg.
module qpwht_datapath import qpwht_pkg::*; #(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF,
  parameter int MAX_WORD   = MAX_WORD_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  qpwht_cmd_t       cmd,
  input  logic [7:0]       char_in,
  output qpwht_sts_t       sts,
  output logic [13:0]      slot_o,
  output logic [13:0]      probes_o
);
  localparam int SW = $clog2(TABLE_SIZE);
  localparam int LW = $clog2(MAX_WORD + 1);
  localparam int KW = 22;
  localparam int TW = 8 * MAX_WORD;
  localparam int CW = $clog2(TABLE_SIZE + 1);
  localparam int INC0 = 4 % TABLE_SIZE;
  // key reduction: offset to a nonnegative value, then reciprocal multiply
  localparam int KNEG   = 158 * 26 * ((MAX_WORD * (MAX_WORD - 1)) / 2);
  localparam int KOFF   = ((KNEG + TABLE_SIZE - 1) / TABLE_SIZE) * TABLE_SIZE;
  localparam int XW     = 23;
  localparam int RS     = 24;
  localparam int MRECIP = (1 << RS) / TABLE_SIZE;
  localparam int MW     = $clog2(MRECIP + 1);

  logic [TW-1:0]        pchars_r;
  logic [LW-1:0]        plen_r;
  logic signed [KW-1:0] pkey_r;
  logic                 plong_r;

  logic [SW-1:0] slot_r, slot_nxt;
  logic [SW-1:0] inc_r;   // 4*i+4 mod size, delta to next probe
  logic [CW-1:0] cnt_r;
  logic [XW-1:0] q_r;     // quotient estimate of offset key

  logic                  used_mem [TABLE_SIZE];
  logic [TW-1:0]         text_mem [TABLE_SIZE];
  logic [LW-1:0]         len_mem  [TABLE_SIZE];
  logic [TW-1:0]         text_q;
  logic [LW-1:0]         len_q;
  logic                  used_q;

  logic [7:0]            uc;
  logic signed [KW-1:0]  term;
  logic [TW-1:0]         mask;
  logic [XW-1:0]         kx;
  logic [XW+MW-1:0]      qprod;
  logic [XW-1:0]         rem0;
  logic [XW-1:0]         kred;
  logic [SW:0]           sum1, sum2;

  always_comb begin
    uc = (char_in >= 8'h61 && char_in <= 8'h7a) ? char_in - 8'd32 : char_in;
    term = $signed((KW'(97) - KW'(uc)) * KW'(26) * KW'(plen_r));
    kx = {{(XW-KW){pkey_r[KW-1]}}, pkey_r} + XW'(KOFF);
    qprod = kx * MW'(MRECIP);
    rem0 = kx - q_r * XW'(TABLE_SIZE);
    kred = (rem0 >= XW'(TABLE_SIZE)) ? rem0 - XW'(TABLE_SIZE) : rem0;
    sum1 = {1'b0, slot_r} + {1'b0, inc_r};
    slot_nxt = (sum1 >= (SW+1)'(TABLE_SIZE)) ? SW'(sum1 - (SW+1)'(TABLE_SIZE)) : SW'(sum1);
    sum2 = {1'b0, inc_r} + (SW+1)'(4);
    for (int k = 0; k < MAX_WORD; k++)
      mask[8*k +: 8] = (k < plen_r) ? 8'hff : 8'h00;
  end

  // estimate is exact or one low; the start cycle corrects it
  always_ff @(posedge clk) begin
    q_r <= XW'(qprod >> RS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_pend) begin
      plen_r  <= '0;
      pkey_r  <= '0;
      plong_r <= 1'b0;
    end else if (cmd.accum) begin
      if (plen_r < LW'(MAX_WORD)) begin
        pkey_r <= pkey_r + term;
        pchars_r[8*plen_r +: 8] <= uc;
        plen_r <= plen_r + LW'(1);
      end else begin
        plong_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      slot_r <= '0;
      inc_r <= '0;
    end else if (cmd.start) begin
      slot_r <= SW'(kred);
      inc_r  <= SW'(INC0);
      cnt_r  <= CW'(1);
    end else if (cmd.clr_mark) begin
      slot_r <= slot_r + SW'(1);
    end else if (cmd.step) begin
      slot_r <= slot_nxt;
      inc_r  <= (sum2 >= (SW+1)'(TABLE_SIZE)) ? SW'(sum2 - (SW+1)'(TABLE_SIZE)) : SW'(sum2);
      cnt_r  <= cnt_r + CW'(1);
    end
  end

  // used marks cleared by a pass over every slot after reset
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      text_mem[slot_r] <= pchars_r;
      len_mem[slot_r]  <= plen_r;
      used_mem[slot_r] <= 1'b1;
    end else if (cmd.clr_mark) begin
      used_mem[slot_r] <= 1'b0;
    end
    if (cmd.rd) begin
      text_q <= text_mem[slot_r];
      len_q  <= len_mem[slot_r];
      used_q <= used_mem[slot_r];
    end
  end

  assign sts.used      = used_q;
  assign sts.match     = (len_q == plen_r) && ((text_q & mask) == (pchars_r & mask));
  assign sts.overlong  = plong_r;
  assign sts.exhausted = (cnt_r >= CW'(TABLE_SIZE));
  assign sts.clr_done  = (slot_r == SW'(TABLE_SIZE - 1));
  assign slot_o        = 14'(slot_r);
  assign probes_o      = 14'(cnt_r);
endmodule

// File: src/qpwht_ctrl.sv
// Controller: sequences character intake, probe walk and result hand-off.
// Depends on qpwht_pkg.
module qpwht_ctrl import qpwht_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_cmd,
  input  logic        in_last,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  out_status,
  output logic        out_zero,
  output qpwht_cmd_t  cmd,
  input  qpwht_sts_t  sts
);
  localparam logic [2:0] S_IDLE = 3'd0, S_START = 3'd1, S_READ = 3'd2,
                         S_WAIT = 3'd3, S_EVAL = 3'd4, S_OUT = 3'd5,
                         S_CLEAR = 3'd6, S_HASH = 3'd7;
  logic [2:0] state_r, state_nxt;
  logic       op_r;
  logic [1:0] st_r, st_nxt;
  logic       zero_r, zero_nxt;
  logic       acc;

  assign in_tready = (state_r == S_IDLE);
  assign acc = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    st_nxt = st_r;
    zero_nxt = zero_r;
    cmd = '0;
    cmd.accum = acc;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_mark = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: if (acc && in_last) state_nxt = S_HASH;
      S_HASH: state_nxt = S_START;
      S_START: begin
        if (sts.overlong) begin
          st_nxt = ST_LONG; zero_nxt = 1'b1; state_nxt = S_OUT;
        end else begin
          cmd.start = 1'b1; state_nxt = S_READ;
        end
      end
      S_READ: begin cmd.rd = 1'b1; state_nxt = S_WAIT; end
      S_WAIT: state_nxt = S_EVAL;
      S_EVAL: begin
        if (!sts.used) begin
          if (op_r == CMD_INSERT) begin
            cmd.wr = 1'b1; st_nxt = ST_OK; zero_nxt = 1'b0;
          end else begin
            st_nxt = ST_NOTFOUND; zero_nxt = 1'b1;
          end
          state_nxt = S_OUT;
        end else if (op_r == CMD_LOOKUP && sts.match) begin
          st_nxt = ST_OK; zero_nxt = 1'b0; state_nxt = S_OUT;
        end else if (sts.exhausted) begin
          st_nxt = (op_r == CMD_INSERT) ? ST_FULL : ST_NOTFOUND;
          zero_nxt = 1'b1; state_nxt = S_OUT;
        end else begin
          cmd.step = 1'b1; state_nxt = S_READ;
        end
      end
      S_OUT: if (out_tready) begin cmd.clr_pend = 1'b1; state_nxt = S_IDLE; end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      op_r <= 1'b0;
      st_r <= ST_OK;
      zero_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      st_r <= st_nxt;
      zero_r <= zero_nxt;
      if (acc && in_last) op_r <= in_cmd;
    end
  end

  assign out_tvalid = (state_r == S_OUT);
  assign out_status = st_r;
  assign out_zero = zero_r;
endmodule

// File: src/quadratic_probe_word_hash_table.sv
// Top level of the quadratic-probe word hash table.
// Joins qpwht_ctrl and qpwht_datapath; depends on qpwht_pkg.
//
// Usage: a word arrives on the in_ channel one character per transfer,
// with in_tlast on its final character; in_tuser carries the command
// (0 insert, 1 look up) and is read on the last transfer. Characters are
// taken one per cycle while in_tready is high. After the last one the key
// is reduced mod TABLE_SIZE by a registered quotient estimate, then a
// correction that loads the first slot; then the block walks probe slots
// (key + 2i + 2i^2) mod TABLE_SIZE, each probe passing through read,
// memory wait and decide states. A word over MAX_WORD characters answers
// status 3 without touching the table. One result transfer per word on
// out_: status, slot, probes. Words are handled one at a time: in_tready
// is low from the last character until the result transfer.
// Reset clears the pending word; the used marks are then cleared by a pass
// over all TABLE_SIZE slots (16381 default) with in_tready low. Stored text
// needs no clearing. While out_tvalid waits for out_tready the result holds
// and in_tready stays low.
module quadratic_probe_word_hash_table import qpwht_pkg::*; #(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF,
  parameter int MAX_WORD   = MAX_WORD_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] character
  input  logic        in_tuser,   // [0] cmd
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [1:0] status, [15:2] slot, [29:16] probe_count
);
  qpwht_cmd_t  cmd;
  qpwht_sts_t  sts;
  logic [1:0]  status;
  logic        zero;
  logic [13:0] slot, probes;

  qpwht_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_cmd(in_tuser), .in_last(in_tlast),
    .out_tvalid, .out_tready, .out_status(status), .out_zero(zero), .cmd, .sts
  );

  qpwht_datapath #(.TABLE_SIZE(TABLE_SIZE), .MAX_WORD(MAX_WORD)) u_dp (
    .clk, .rst_n, .cmd, .char_in(in_tdata), .sts, .slot_o(slot), .probes_o(probes)
  );

  // long word reports zero probes; other failures report slot 0
  assign out_tdata = {2'b00,
                      (status == ST_LONG) ? 14'd0 : probes,
                      zero ? 14'd0 : slot,
                      status};
endmodule

// File: src/qpwht_checker.sv
// Port-level checker for the word hash table, bound to the top level.
// Depends on qpwht_pkg and the top level's ports.
module qpwht_checker import qpwht_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input open while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed under stall");
  a_long: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == ST_LONG |-> out_tdata[29:2] == 28'd0)
    else $error("long word result not zero");
  a_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != ST_OK |-> out_tdata[15:2] == 14'd0)
    else $error("failed result has slot");
endmodule

bind quadratic_probe_word_hash_table qpwht_checker u_chk (
  .clk, .rst_n, .in_tready, .out_tvalid, .out_tready, .out_tdata
);

// File: dv/tb.sv
// Self-checking bench for quadratic_probe_word_hash_table: words in, status/slot/probes out.
// Needs qpwht_pkg and the table RTL; carries its own table predictor and result queue.
`timescale 1ns / 100ps

module tb;
  import qpwht_pkg::*;

  localparam int TSIZE   = TABLE_SIZE_DEF;
  localparam int MAXW    = MAX_WORD_DEF;
  localparam int LIMIT   = 3_000_000;  // cycles; far above the slowest legal run
  localparam int N_ITEMS = 1000;

  typedef struct {
    logic [7:0] ch[32];
    int         n;
  } word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [13:0] slot;
    logic [13:0] probes;
  } answer_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] character
  logic        in_tuser;   // [0] cmd
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [1:0] status, [15:2] slot, [29:16] probe_count

  quadratic_probe_word_hash_table u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Table predictor: mirrors the used marks, stored words and pending word
  // ---------------------------------------------------------------------
  bit         tbl_used[TSIZE];
  logic [7:0] tbl_text[TSIZE][MAXW];
  int         tbl_len[TSIZE];
  logic [7:0] word_chars[MAXW];
  int         word_len;
  int         word_key;
  bit         word_long;

  answer_t    answers_due[$];
  int         mismatches;
  int         stray_results;
  int         items_sent;

  bit         tx_idle_en;   // sender gaps on/off
  bit         rx_idle_en;   // receiver stalls on/off
  bit         hold_req;     // ask the receiver for one long hold-off

  function automatic int probe_at(int key, int i);
    longint v;
    longint r;
    v = longint'(key) + 2 * longint'(i) + 2 * longint'(i) * longint'(i);
    r = v % TSIZE;
    if (r < 0) r += TSIZE;
    return int'(r);
  endfunction

  function automatic bit word_matches(int s);
    if (tbl_len[s] != word_len) return 0;
    for (int j = 0; j < word_len; j++)
      if (tbl_text[s][j] !== word_chars[j]) return 0;
    return 1;
  endfunction

  // Fold one accepted transfer into the pending word; on tlast, resolve it.
  function automatic void table_absorb(logic cmd, logic [7:0] c_raw, logic last);
    logic [7:0] c;
    answer_t    a;
    int         s;
    int         cv;
    c = c_raw;
    if (c >= "a" && c <= "z") c = c - 8'd32;
    if (word_len < MAXW) begin
      cv = c;
      word_key += (97 - cv) * 26 * word_len;
      word_chars[word_len] = c;
      word_len++;
    end else begin
      word_long = 1;
    end
    if (!last) return;

    a.slot = '0;
    a.probes = '0;
    if (word_long) begin
      a.status = ST_LONG;
    end else if (cmd == CMD_INSERT) begin
      a.status = ST_FULL;
      a.probes = 14'(TSIZE);
      for (int i = 0; i < TSIZE; i++) begin
        s = probe_at(word_key, i);
        if (!tbl_used[s]) begin
          tbl_used[s] = 1;
          for (int j = 0; j < word_len; j++) tbl_text[s][j] = word_chars[j];
          tbl_len[s] = word_len;
          a.status = ST_OK;
          a.slot   = 14'(s);
          a.probes = 14'(i + 1);
          break;
        end
      end
    end else begin
      a.status = ST_NOTFOUND;
      a.probes = 14'(TSIZE);
      for (int i = 0; i < TSIZE; i++) begin
        s = probe_at(word_key, i);
        if (!tbl_used[s]) begin
          a.probes = 14'(i + 1);
          break;
        end
        if (word_matches(s)) begin
          a.status = ST_OK;
          a.slot   = 14'(s);
          a.probes = 14'(i + 1);
          break;
        end
      end
    end
    answers_due.push_back(a);
    word_len  = 0;
    word_key  = 0;
    word_long = 0;
  endfunction

  // ---------------------------------------------------------------------
  // Result checker: every out_ transfer against the oldest expectation
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    answer_t a;
    answer_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = out_tdata[1:0];
      got.slot   = out_tdata[15:2];
      got.probes = out_tdata[29:16];
      if (answers_due.size() == 0) begin
        stray_results++;
        if (mismatches + stray_results <= 10)
          $display("unexpected result transfer: %h", out_tdata);
      end else begin
        a = answers_due.pop_front();
        if (got !== a) begin
          mismatches++;
          if (mismatches + stray_results <= 10)
            $display("mismatch: exp status %0d slot %0d probes %0d, got %0d %0d %0d",
                     a.status, a.slot, a.probes, got.status, got.slot, got.probes);
        end
      end
    end
  end

  // Receiver: random stalls, occasional long ones, and the requested hold-off.
  initial out_tready = 1'b0;
  always begin : rx_ready_gen
    int r;
    @(posedge clk);
    if (hold_req) begin
      out_tready <= 1'b0;
      repeat (400) @(posedge clk);
      hold_req = 0;
    end else if (!rx_idle_en) begin
      out_tready <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end else begin
        out_tready <= (r >= 30);
      end
    end
  end

  // Watchdog
  always begin : watchdog
    repeat (LIMIT) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (!tx_idle_en) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_char(logic [7:0] c, logic cmd, logic last);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tuser  <= cmd;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    table_absorb(cmd, c, last);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_word(word_t w, logic cmd);
    for (int i = 0; i < w.n; i++) send_char(w.ch[i], cmd, i == w.n - 1);
  endtask

  function automatic word_t from_text(string s);
    word_t w;
    w.n = s.len();
    for (int i = 0; i < w.n; i++) w.ch[i] = s[i];
    return w;
  endfunction

  // Letters in mixed case; len picks the word length.
  function automatic word_t letter_word(int len);
    word_t w;
    w.n = len;
    for (int i = 0; i < len; i++)
      w.ch[i] = 8'($urandom_range(0, 25)) + ($urandom_range(0, 1) ? "a" : "A");
    return w;
  endfunction

  // Same word with letters flipped in case at random - must still match.
  function automatic word_t recase(word_t w);
    for (int i = 0; i < w.n; i++)
      if ($urandom_range(0, 1) && ((w.ch[i] >= "a" && w.ch[i] <= "z") ||
                                   (w.ch[i] >= "A" && w.ch[i] <= "Z")))
        w.ch[i] = w.ch[i] ^ 8'h20;
    return w;
  endfunction

  task automatic drain();
    in_tvalid <= 1'b0;
    while (answers_due.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  task automatic test_basic_words();
    word_t w;
    send_word(from_text("a"), CMD_LOOKUP);            // empty table: miss at once
    send_word(from_text("a"), CMD_INSERT);
    send_word(from_text("A"), CMD_INSERT);            // same key, collides
    send_word(from_text("z"), CMD_INSERT);
    send_word(from_text("Z"), CMD_LOOKUP);
    send_word(from_text("abc"), CMD_INSERT);
    send_word(from_text("ab"), CMD_LOOKUP);           // prefix: differs in length
    send_word(from_text("ABC"), CMD_LOOKUP);
    send_word(from_text("{`@["), CMD_INSERT);         // neighbours of the letter ranges
    send_word(from_text("{`@["), CMD_LOOKUP);
    w.n = 4;
    w.ch[0] = 8'h00; w.ch[1] = 8'hff; w.ch[2] = 8'h55; w.ch[3] = 8'haa;
    send_word(w, CMD_INSERT);                         // zero and all-ones bytes
    send_word(w, CMD_LOOKUP);
    w.ch[3] = 8'h00;
    send_word(w, CMD_LOOKUP);
    drain();
  endtask

  task automatic test_word_length();
    word_t w;
    w = letter_word(MAXW);                            // longest legal word
    send_word(w, CMD_INSERT);
    send_word(recase(w), CMD_LOOKUP);
    w = letter_word(MAXW + 1);                        // one character over
    send_word(w, CMD_INSERT);
    send_word(w, CMD_LOOKUP);
    send_word(letter_word(31), CMD_INSERT);
    w.n = MAXW;                                       // clipped copy never got stored
    send_word(w, CMD_LOOKUP);
    drain();
  endtask

  task automatic test_random_traffic();
    word_t vocab[$];
    word_t w;
    int r;
    while (items_sent < N_ITEMS) begin
      if ($urandom_range(0, 99) < 8) begin
        tx_idle_en = $urandom_range(0, 3) != 0;
        rx_idle_en = $urandom_range(0, 3) != 0;
      end
      r = $urandom_range(0, 99);
      if (r < 45 || vocab.size() == 0) begin
        w = letter_word($urandom_range(0, 9) == 0 ? $urandom_range(9, MAXW)
                                                   : $urandom_range(1, 8));
        vocab.push_back(w);
        send_word(w, CMD_INSERT);
      end else if (r < 80) begin
        send_word(recase(vocab[$urandom_range(0, vocab.size() - 1)]), CMD_LOOKUP);
      end else if (r < 88) begin
        send_word(letter_word($urandom_range(1, 8)), CMD_LOOKUP);
      end else if (r < 93) begin
        send_word(letter_word($urandom_range(MAXW + 1, 26)), 1'($urandom_range(0, 1)));
      end else begin
        w.n = $urandom_range(1, 6);                   // raw bytes, any value
        for (int i = 0; i < w.n; i++) w.ch[i] = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 1)) vocab.push_back(w);
        send_word(w, 1'($urandom_range(0, 1)));
      end
    end
    drain();
  endtask

  task automatic test_output_backpressure();
    tx_idle_en = 0;
    hold_req = 1;
    for (int k = 0; k < 6; k++) send_word(letter_word($urandom_range(2, 5)), CMD_INSERT);
    drain();
  endtask

  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= 1'b0;
    in_tlast   <= 1'b0;
    tx_idle_en = 1;
    rx_idle_en = 1;
    hold_req   = 0;
    word_len   = 0;
    word_key   = 0;
    word_long  = 0;
    mismatches = 0;
    stray_results = 0;
    items_sent = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_words();
    test_word_length();
    test_output_backpressure();
    test_random_traffic();
    rx_idle_en = 1;
    test_output_backpressure();

    repeat (50) @(posedge clk);
    if (mismatches == 0 && stray_results == 0 && answers_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
